/* hw/rtl/are_pkg.sv */
// Shared types, sizes and codes of the ARP resolution engine.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package are_pkg;

    localparam int CACHE_ENTRIES   = 32;
    localparam int PENDING_ENTRIES = 16;
    localparam int QUEUE_DEPTH     = 16;
    localparam int RESULT_LIMIT    = 16;

    localparam int TICK_STEPS = (CACHE_ENTRIES > PENDING_ENTRIES) ? CACHE_ENTRIES
                                                                  : PENDING_ENTRIES;
    localparam int SCAN_MAX   = (TICK_STEPS > QUEUE_DEPTH) ? TICK_STEPS : QUEUE_DEPTH;
    localparam int STEP_W     = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;
    localparam int CIDX_W     = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIDX_W     = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int SIDX_W     = (CIDX_W > PIDX_W) ? CIDX_W : PIDX_W;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int REL_W      = $clog2(RESULT_LIMIT + 1);

    localparam logic [15:0] LIFETIME_RESET = 16'd30000;
    localparam logic [15:0] RETRY_RESET    = 16'd5000;
    localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] FT_ARP  = 2'd0;
    localparam logic [1:0] FT_IPV4 = 2'd1;

    localparam logic [1:0] ARP_REQ   = 2'd0;
    localparam logic [1:0] ARP_REPLY = 2'd1;

    localparam logic [2:0] KIND_TX      = 3'd0;
    localparam logic [2:0] KIND_REQUEST = 3'd1;
    localparam logic [2:0] KIND_REPLY   = 3'd2;
    localparam logic [2:0] KIND_DELIVER = 3'd3;
    localparam logic [2:0] KIND_DROP    = 3'd4;

    localparam logic [1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [1:0] REG_OWN_IP   = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;
    localparam logic [1:0] REG_RETRY    = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] rem;
    } cache_ent_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [15:0] rem;
    } pend_ent_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] handle;
    } queue_ent_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] dst_mac;
        logic [31:0] tip;
        logic [47:0] tmac;
        logic [15:0] handle;
    } res_t;

endpackage

`default_nettype wire

/* hw/rtl/are_cache_cell.sv */
// One cache cell of the rotating cache ring.
// Depends on are_pkg for the entry type.
`default_nettype none

module are_cache_cell
    import are_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire cache_ent_t d,
    output cache_ent_t      q
);

    logic        valid_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [15:0] rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ip_reg  <= d.ip;
            mac_reg <= d.mac;
            rem_reg <= d.rem;
        end
    end

    assign q = '{valid: valid_reg, ip: ip_reg, mac: mac_reg, rem: rem_reg};

endmodule

`default_nettype wire

/* hw/rtl/are_pend_cell.sv */
// One cell of the rotating outstanding-request ring.
// Depends on are_pkg for the entry type.
`default_nettype none

module are_pend_cell
    import are_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire pend_ent_t d,
    output pend_ent_t      q
);

    logic        valid_reg;
    logic [31:0] ip_reg;
    logic [15:0] rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ip_reg  <= d.ip;
            rem_reg <= d.rem;
        end
    end

    assign q = '{valid: valid_reg, ip: ip_reg, rem: rem_reg};

endmodule

`default_nettype wire

/* hw/rtl/are_queue_cell.sv */
// One slot of the shifting hold queue; occupancy is tracked by a fill count outside.
// Depends on are_pkg for the entry type.
`default_nettype none

module are_queue_cell
    import are_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire queue_ent_t d,
    output queue_ent_t      q
);

    queue_ent_t ent_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_reg <= d;
        end
    end

    assign q = ent_reg;

endmodule

`default_nettype wire

/* hw/rtl/arp_resolution_engine_top.sv */
// ARP resolution engine: sequencer, result buffering and the three cell chains.
// Depends on are_pkg, are_cache_cell, are_pend_cell and are_queue_cell.
`default_nettype none

// One transaction at a time. Cache and request tables are rings of cells that rotate one
// entry per cycle past a single head stage; each operation is a sequence of passes:
// a send scans the cache, on a miss the request table, opens a request if none is
// open and queues the handle; a reply scans the requests, scans and writes the cache,
// then the queue; a request for us scans and writes the cache; a tick ages both rings.
// The final flush, a dropped result and the queue release (one handle per cycle) wait
// while the output is stalled. Results pass through a one-deep hold stage so the final
// one carries last. No clearing pass after reset.
module arp_resolution_engine_top
    import are_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [47:0] wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] next_hop_ip,
    input  wire logic [15:0] datagram_handle,
    input  wire logic [47:0] frame_dst_mac,
    input  wire logic [1:0]  frame_type,
    input  wire logic [1:0]  arp_opcode,
    input  wire logic [31:0] sender_ip,
    input  wire logic [47:0] sender_mac,
    input  wire logic [31:0] target_ip,
    input  wire logic        payload_ok,
    input  wire logic [31:0] elapsed_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [47:0]      dst_mac,
    output logic [31:0]      arp_target_ip,
    output logic [47:0]      arp_target_mac,
    output logic [15:0]      handle_out,
    output logic             last
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CSCAN  = 4'd1;
    localparam logic [3:0] S_CWRITE = 4'd2;
    localparam logic [3:0] S_PSCAN  = 4'd3;
    localparam logic [3:0] S_PWRITE = 4'd4;
    localparam logic [3:0] S_QAPP   = 4'd5;
    localparam logic [3:0] S_QSCAN  = 4'd6;
    localparam logic [3:0] S_TICK   = 4'd7;
    localparam logic [3:0] S_FLUSH  = 4'd8;

    localparam logic [1:0] MODE_SEND  = 2'd0;
    localparam logic [1:0] MODE_REQ   = 2'd1;
    localparam logic [1:0] MODE_REPLY = 2'd2;

    // configuration
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [15:0] lifetime_reg;
    logic [15:0] retry_reg;

    // control
    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic              held_valid_reg;
    logic              out_valid_reg;

    // transaction payload
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] key_reg;
    logic [15:0] handle_reg;
    logic [47:0] smac_reg;
    logic [31:0] el_reg;

    // scan collectors
    logic              hit_reg, hit_next;
    logic [SIDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [47:0]       hit_mac_reg, hit_mac_next;
    logic              free_found_reg, free_found_next;
    logic [SIDX_W-1:0] free_idx_reg, free_idx_next;
    logic [SIDX_W-1:0] min_idx_reg, min_idx_next;
    logic [15:0]       min_rem_reg, min_rem_next;
    logic [SIDX_W-1:0] slot_reg, slot_sel;
    logic [STEP_W-1:0] scan_last_reg, scan_last_next;
    logic [REL_W-1:0]  rel_reg, rel_next;

    res_t held_reg;
    res_t out_reg;
    logic out_last_reg;

    cache_ent_t c_q   [CACHE_ENTRIES];
    cache_ent_t c_new;
    pend_ent_t  p_q   [PENDING_ENTRIES];
    pend_ent_t  p_new;
    queue_ent_t q_q   [QUEUE_DEPTH];
    queue_ent_t q_new;

    logic              accept;
    logic              for_us;
    logic              first;
    logic [SIDX_W-1:0] head_idx;
    logic              c_end, p_end, t_end;
    logic              c_shift, p_shift;
    logic              s_valid;
    logic [31:0]       s_ip;
    logic [15:0]       s_rem;
    logic              cur_hit, cur_free, cur_min, ff_prev;
    logic              q_match, q_adv, q_push, q_app;
    logic              out_free, emit_ok, emit_en, push;
    res_t              emit_res;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign for_us   = (frame_dst_mac == MAC_BCAST) || (frame_dst_mac == own_mac_reg);

    assign first    = (step_reg == '0);
    assign head_idx = step_reg[SIDX_W-1:0];
    assign c_end    = (step_reg == STEP_W'(CACHE_ENTRIES - 1));
    assign p_end    = (step_reg == STEP_W'(PENDING_ENTRIES - 1));
    assign t_end    = (step_reg == STEP_W'(TICK_STEPS - 1));

    assign c_shift = (state_reg == S_CSCAN) || (state_reg == S_CWRITE) ||
                     ((state_reg == S_TICK) && (step_reg <= STEP_W'(CACHE_ENTRIES - 1)));
    assign p_shift = (state_reg == S_PSCAN) || (state_reg == S_PWRITE) ||
                     ((state_reg == S_TICK) && (step_reg <= STEP_W'(PENDING_ENTRIES - 1)));

    // ---------------- scan collectors over the ring heads ----------------
    always_comb
    begin
        if (state_reg == S_CSCAN)
        begin
            s_valid = c_q[0].valid;
            s_ip    = c_q[0].ip;
            s_rem   = c_q[0].rem;
        end
        else
        begin
            s_valid = p_q[0].valid;
            s_ip    = p_q[0].ip;
            s_rem   = p_q[0].rem;
        end
        cur_hit         = s_valid && (s_ip == key_reg);
        hit_next        = (first ? 1'b0 : hit_reg) | cur_hit;
        hit_idx_next    = cur_hit ? head_idx : hit_idx_reg;
        hit_mac_next    = cur_hit ? c_q[0].mac : hit_mac_reg;
        ff_prev         = first ? 1'b0 : free_found_reg;
        cur_free        = !s_valid && !ff_prev;
        free_found_next = ff_prev | !s_valid;
        free_idx_next   = cur_free ? head_idx : free_idx_reg;
        cur_min         = first || (s_rem < min_rem_reg);
        min_idx_next    = cur_min ? head_idx : min_idx_reg;
        min_rem_next    = cur_min ? s_rem : min_rem_reg;
        if (hit_next)
        begin
            slot_sel = hit_idx_next;
        end
        else if (free_found_next)
        begin
            slot_sel = free_idx_next;
        end
        else
        begin
            slot_sel = min_idx_next;
        end
    end

    // ---------------- head stages of the rings ----------------
    always_comb
    begin
        c_new = c_q[0];
        if ((state_reg == S_CWRITE) && (head_idx == slot_reg))
        begin
            c_new.valid = 1'b1;
            c_new.ip    = key_reg;
            c_new.mac   = smac_reg;
            c_new.rem   = lifetime_reg;
        end
        else if ((state_reg == S_TICK) && c_q[0].valid)
        begin
            if ({16'd0, c_q[0].rem} <= el_reg)
            begin
                c_new.valid = 1'b0;
            end
            else
            begin
                c_new.rem = c_q[0].rem - el_reg[15:0];
            end
        end
    end

    always_comb
    begin
        p_new = p_q[0];
        if ((state_reg == S_PSCAN) && (mode_reg == MODE_REPLY) && cur_hit)
        begin
            p_new.valid = 1'b0;
        end
        else if ((state_reg == S_PWRITE) && (head_idx == slot_reg))
        begin
            p_new.valid = 1'b1;
            p_new.ip    = key_reg;
            p_new.rem   = retry_reg;
        end
        else if ((state_reg == S_TICK) && p_q[0].valid)
        begin
            if ({16'd0, p_q[0].rem} <= el_reg)
            begin
                p_new.valid = 1'b0;
            end
            else
            begin
                p_new.rem = p_q[0].rem - el_reg[15:0];
            end
        end
    end

    // ---------------- queue control ----------------
    assign q_match = (q_q[0].ip == key_reg) && (rel_reg < REL_W'(RESULT_LIMIT));
    assign q_adv   = (state_reg == S_QSCAN) && (!q_match || emit_ok);
    assign q_push  = q_adv && !q_match;
    assign q_app   = (state_reg == S_QAPP) && (qcnt_reg < QCNT_W'(QUEUE_DEPTH));
    assign q_new   = q_app ? '{ip: key_reg, handle: handle_reg} : q_q[0];

    // ---------------- cell chains ----------------
    genvar gi;
    generate
        for (gi = 0; gi < CACHE_ENTRIES; gi++)
        begin : g_cache
            cache_ent_t d_c;
            if (gi == CACHE_ENTRIES - 1)
            begin : g_tail
                assign d_c = c_new;
            end
            else
            begin : g_mid
                assign d_c = c_q[gi + 1];
            end
            are_cache_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (c_shift),
                .d     (d_c),
                .q     (c_q[gi])
            );
        end

        for (gi = 0; gi < PENDING_ENTRIES; gi++)
        begin : g_pend
            pend_ent_t d_p;
            if (gi == PENDING_ENTRIES - 1)
            begin : g_tail
                assign d_p = p_new;
            end
            else
            begin : g_mid
                assign d_p = p_q[gi + 1];
            end
            are_pend_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (p_shift),
                .d     (d_p),
                .q     (p_q[gi])
            );
        end

        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_queue
            queue_ent_t shifted;
            logic       en_q;
            queue_ent_t d_q;
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign shifted = q_q[0];
            end
            else
            begin : g_mid
                assign shifted = q_q[gi + 1];
            end
            // kept entries re-enter just behind the last live slot
            assign en_q = q_adv || (q_app && (qcnt_reg == QCNT_W'(gi)));
            assign d_q  = (q_app || (q_push && (qcnt_reg == QCNT_W'(gi + 1)))) ? q_new
                                                                               : shifted;
            are_queue_cell u_cell (
                .clk (clk),
                .en  (en_q),
                .d   (d_q),
                .q   (q_q[gi])
            );
        end
    endgenerate

    // ---------------- result path ----------------
    assign out_free = !out_valid_reg || !out_stall;
    assign emit_ok  = !held_valid_reg || out_free;
    assign push     = held_valid_reg && out_free && (emit_en || (state_reg == S_FLUSH));

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mode_next      = mode_reg;
        qcnt_next      = qcnt_reg;
        scan_last_next = scan_last_reg;
        rel_next       = rel_reg;
        emit_en        = 1'b0;
        emit_res       = '0;
        if (q_app)
        begin
            qcnt_next = qcnt_reg + QCNT_W'(1);
        end
        else if (q_adv && q_match)
        begin
            qcnt_next = qcnt_reg - QCNT_W'(1);
        end
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    unique case (operation)
                        OP_SEND:
                        begin
                            mode_next  = MODE_SEND;
                            state_next = S_CSCAN;
                        end
                        OP_RECV:
                        begin
                            if (for_us && (frame_type == FT_ARP))
                            begin
                                if ((arp_opcode == ARP_REQ) && (target_ip == own_ip_reg))
                                begin
                                    mode_next  = MODE_REQ;
                                    state_next = S_CSCAN;
                                end
                                else if (arp_opcode == ARP_REPLY)
                                begin
                                    mode_next  = MODE_REPLY;
                                    state_next = S_PSCAN;
                                end
                            end
                            else if (for_us && (frame_type == FT_IPV4) && payload_ok)
                            begin
                                emit_en         = 1'b1;
                                emit_res.kind   = KIND_DELIVER;
                                emit_res.handle = datagram_handle;
                                state_next      = S_FLUSH;
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = S_TICK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CSCAN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (c_end)
                begin
                    step_next = '0;
                    if (mode_reg == MODE_SEND)
                    begin
                        if (hit_next)
                        begin
                            emit_en          = 1'b1;
                            emit_res.kind    = KIND_TX;
                            emit_res.dst_mac = hit_mac_next;
                            emit_res.handle  = handle_reg;
                            state_next       = S_FLUSH;
                        end
                        else
                        begin
                            state_next = S_PSCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_CWRITE;
                    end
                end
            end
            S_CWRITE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (c_end)
                begin
                    step_next = '0;
                    if (mode_reg == MODE_REQ)
                    begin
                        emit_en          = 1'b1;
                        emit_res.kind    = KIND_REPLY;
                        emit_res.dst_mac = smac_reg;
                        emit_res.tip     = key_reg;
                        emit_res.tmac    = smac_reg;
                        state_next       = S_FLUSH;
                    end
                    else
                    begin
                        rel_next       = '0;
                        scan_last_next = STEP_W'(qcnt_reg - QCNT_W'(1));
                        state_next     = (qcnt_reg == '0) ? S_FLUSH : S_QSCAN;
                    end
                end
            end
            S_PSCAN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (p_end)
                begin
                    step_next = '0;
                    if (mode_reg == MODE_SEND)
                    begin
                        if (hit_next)
                        begin
                            state_next = S_QAPP;
                        end
                        else
                        begin
                            emit_en          = 1'b1;
                            emit_res.kind    = KIND_REQUEST;
                            emit_res.dst_mac = MAC_BCAST;
                            emit_res.tip     = key_reg;
                            state_next       = S_PWRITE;
                        end
                    end
                    else
                    begin
                        state_next = S_CSCAN;
                    end
                end
            end
            S_PWRITE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (p_end)
                begin
                    step_next  = '0;
                    state_next = S_QAPP;
                end
            end
            S_QAPP:
            begin
                if (q_app)
                begin
                    state_next = S_FLUSH;
                end
                else if (emit_ok)
                begin
                    emit_en         = 1'b1;
                    emit_res.kind   = KIND_DROP;
                    emit_res.handle = handle_reg;
                    state_next      = S_FLUSH;
                end
            end
            S_QSCAN:
            begin
                if (q_adv)
                begin
                    if (q_match)
                    begin
                        emit_en          = 1'b1;
                        emit_res.kind    = KIND_TX;
                        emit_res.dst_mac = smac_reg;
                        emit_res.handle  = q_q[0].handle;
                        rel_next         = rel_reg + REL_W'(1);
                    end
                    if (step_reg == scan_last_reg)
                    begin
                        step_next  = '0;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            S_TICK:
            begin
                step_next = step_reg + STEP_W'(1);
                if (t_end)
                begin
                    step_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (!held_valid_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg    <= '0;
            own_ip_reg     <= '0;
            lifetime_reg   <= LIFETIME_RESET;
            retry_reg      <= RETRY_RESET;
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            qcnt_reg       <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_OWN_MAC:  own_mac_reg  <= wr_data;
                    REG_OWN_IP:   own_ip_reg   <= wr_data[31:0];
                    REG_LIFETIME: lifetime_reg <= wr_data[15:0];
                    REG_RETRY:    retry_reg    <= wr_data[15:0];
                    default:      own_mac_reg  <= own_mac_reg;
                endcase
            end
            state_reg <= state_next;
            step_reg  <= step_next;
            qcnt_reg  <= qcnt_next;
            if (emit_en)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                held_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        scan_last_reg  <= scan_last_next;
        rel_reg        <= rel_next;
        if (accept)
        begin
            key_reg    <= (operation == OP_SEND) ? next_hop_ip : sender_ip;
            handle_reg <= datagram_handle;
            smac_reg   <= sender_mac;
            el_reg     <= elapsed_ms;
        end
        if ((state_reg == S_CSCAN) || (state_reg == S_PSCAN))
        begin
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            hit_mac_reg    <= hit_mac_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            min_idx_reg    <= min_idx_next;
            min_rem_reg    <= min_rem_next;
        end
        if (((state_reg == S_CSCAN) && c_end) || ((state_reg == S_PSCAN) && p_end))
        begin
            slot_reg <= slot_sel;
        end
        if (emit_en)
        begin
            held_reg <= emit_res;
        end
        if (push)
        begin
            out_reg      <= held_reg;
            out_last_reg <= (state_reg == S_FLUSH);
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign dst_mac        = out_reg.dst_mac;
    assign arp_target_ip  = out_reg.tip;
    assign arp_target_mac = out_reg.tmac;
    assign handle_out     = out_reg.handle;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for arp_resolution_engine_top: directed table, then random traffic.
// Depends on are_pkg; predicts every result with its own model of the cache, requests and queue.
`timescale 1ns / 1ps

module tb_top
    import are_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 200;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] nh_ip;
        logic [15:0] hdl;
        logic [47:0] fdst;
        logic [1:0]  ftype;
        logic [1:0]  opc;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [31:0] tip;
        logic        pok;
        logic [31:0] el;
    } arp_item_t;

    typedef struct {
        logic [2:0]  kind;
        logic [47:0] dmac;
        logic [31:0] tip;
        logic [47:0] tmac;
        logic [15:0] hdl;
        logic        lst;
    } arp_result_t;

    typedef enum int {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_mode_t;

    typedef struct {
        arp_item_t   it;
        chk_mode_t   mode;
        arp_result_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [47:0] wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [31:0] next_hop_ip = '0;
    logic [15:0] datagram_handle = '0;
    logic [47:0] frame_dst_mac = '0;
    logic [1:0]  frame_type = '0;
    logic [1:0]  arp_opcode = '0;
    logic [31:0] sender_ip = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] target_ip = '0;
    logic        payload_ok = 1'b0;
    logic [31:0] elapsed_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [47:0] dst_mac;
    logic [31:0] arp_target_ip;
    logic [47:0] arp_target_mac;
    logic [15:0] handle_out;
    logic        last;

    arp_resolution_engine_top DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [47:0] m_own_mac;
    logic [31:0] m_own_ip;
    logic [15:0] m_lifetime;
    logic [15:0] m_retry;
    logic        c_valid [CACHE_ENTRIES];
    logic [31:0] c_ip    [CACHE_ENTRIES];
    logic [47:0] c_mac   [CACHE_ENTRIES];
    logic [15:0] c_rem   [CACHE_ENTRIES];
    logic        p_valid [PENDING_ENTRIES];
    logic [31:0] p_ip    [PENDING_ENTRIES];
    logic [15:0] p_rem   [PENDING_ENTRIES];
    logic        q_valid [QUEUE_DEPTH];
    logic [31:0] q_ip    [QUEUE_DEPTH];
    logic [15:0] q_hdl   [QUEUE_DEPTH];

    arp_result_t step_out[$];
    arp_result_t expected_results[$];
    int          errors = 0;
    int          cycles = 0;
    int          out_pct = 0;
    logic [31:0] ip_pool [40];
    logic [47:0] mac_pool [8];

    function automatic void emit(logic [2:0] k, logic [47:0] dm, logic [31:0] ti,
                                 logic [47:0] tm, logic [15:0] h);
        if (step_out.size() < RESULT_LIMIT)
            step_out.insert(step_out.size(), '{k, dm, ti, tm, h, 1'b0});
    endfunction

    function automatic int cache_lookup(logic [31:0] ip);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (c_valid[i] && c_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic int pending_lookup(logic [31:0] ip);
        for (int i = 0; i < PENDING_ENTRIES; i++)
            if (p_valid[i] && p_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
        int slot;
        slot = cache_lookup(ip);
        for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
            if (!c_valid[i])
                slot = i;
        if (slot < 0)
        begin
            slot = 0;
            for (int i = 1; i < CACHE_ENTRIES; i++)
                if (c_rem[i] < c_rem[slot])
                    slot = i;
        end
        c_valid[slot] = 1'b1;
        c_ip[slot]    = ip;
        c_mac[slot]   = mac;
        c_rem[slot]   = m_lifetime;
    endfunction

    function automatic void open_request(logic [31:0] ip);
        int slot;
        slot = -1;
        for (int i = 0; i < PENDING_ENTRIES && slot < 0; i++)
            if (!p_valid[i])
                slot = i;
        if (slot < 0)
        begin
            slot = 0;
            for (int i = 1; i < PENDING_ENTRIES; i++)
                if (p_rem[i] < p_rem[slot])
                    slot = i;
        end
        p_valid[slot] = 1'b1;
        p_ip[slot]    = ip;
        p_rem[slot]   = m_retry;
    endfunction

    function automatic int queue_len();
        int n;
        n = 0;
        while (n < QUEUE_DEPTH && q_valid[n])
            n++;
        return n;
    endfunction

    function automatic void handle_send(logic [31:0] ip, logic [15:0] h);
        int c;
        int q;
        c = cache_lookup(ip);
        if (c >= 0)
        begin
            emit(KIND_TX, c_mac[c], '0, '0, h);
            return;
        end
        if (pending_lookup(ip) < 0)
        begin
            emit(KIND_REQUEST, MAC_BCAST, ip, '0, '0);
            open_request(ip);
        end
        q = queue_len();
        if (q < QUEUE_DEPTH)
        begin
            q_valid[q] = 1'b1;
            q_ip[q]    = ip;
            q_hdl[q]   = h;
        end
        else
            emit(KIND_DROP, '0, '0, '0, h);
    endfunction

    function automatic void handle_reply(logic [31:0] ip, logic [47:0] mac);
        int p;
        int w;
        int cnt;
        p   = pending_lookup(ip);
        w   = 0;
        cnt = queue_len();
        if (p >= 0)
            p_valid[p] = 1'b0;
        learn_mapping(ip, mac);
        for (int i = 0; i < cnt; i++)
        begin
            if (q_ip[i] == ip && step_out.size() < RESULT_LIMIT)
                emit(KIND_TX, mac, '0, '0, q_hdl[i]);
            else
            begin
                q_ip[w]  = q_ip[i];
                q_hdl[w] = q_hdl[i];
                w++;
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_valid[i] = (i < w);
    endfunction

    function automatic void handle_frame(arp_item_t it);
        if (it.fdst != MAC_BCAST && it.fdst != m_own_mac)
            return;
        if (it.ftype == FT_ARP)
        begin
            if (it.opc == ARP_REQ)
            begin
                if (it.tip != m_own_ip)
                    return;
                learn_mapping(it.sip, it.smac);
                emit(KIND_REPLY, it.smac, it.sip, it.smac, '0);
            end
            else if (it.opc == ARP_REPLY)
                handle_reply(it.sip, it.smac);
        end
        else if (it.ftype == FT_IPV4 && it.pok)
            emit(KIND_DELIVER, '0, '0, '0, it.hdl);
    endfunction

    function automatic void age_tables(logic [31:0] el);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (c_valid[i])
            begin
                if ({16'd0, c_rem[i]} <= el)
                    c_valid[i] = 1'b0;
                else
                    c_rem[i] = c_rem[i] - el[15:0];
            end
        for (int i = 0; i < PENDING_ENTRIES; i++)
            if (p_valid[i])
            begin
                if ({16'd0, p_rem[i]} <= el)
                    p_valid[i] = 1'b0;
                else
                    p_rem[i] = p_rem[i] - el[15:0];
            end
    endfunction

    function automatic void predict(arp_item_t it);
        step_out.delete();
        if (it.op == OP_SEND)
            handle_send(it.nh_ip, it.hdl);
        else if (it.op == OP_RECV)
            handle_frame(it);
        else if (it.op == OP_TICK)
            age_tables(it.el);
        if (step_out.size() > 0)
            step_out[$].lst = 1'b1;
    endfunction

    function automatic arp_item_t blank_item();
        arp_item_t it;
        it = '{op: OP_TICK, nh_ip: '0, hdl: '0, fdst: '0, ftype: FT_ARP, opc: ARP_REQ,
               sip: '0, smac: '0, tip: '0, pok: 1'b0, el: '0};
        return it;
    endfunction

    function automatic arp_item_t mk_send(logic [31:0] ip, logic [15:0] h);
        arp_item_t it;
        it       = blank_item();
        it.op    = OP_SEND;
        it.nh_ip = ip;
        it.hdl   = h;
        return it;
    endfunction

    function automatic arp_item_t mk_frame(logic [47:0] d, logic [1:0] ft, logic [1:0] oc,
                                           logic [31:0] si, logic [47:0] sm, logic [31:0] ti,
                                           logic pk, logic [15:0] h);
        arp_item_t it;
        it       = blank_item();
        it.op    = OP_RECV;
        it.fdst  = d;
        it.ftype = ft;
        it.opc   = oc;
        it.sip   = si;
        it.smac  = sm;
        it.tip   = ti;
        it.pok   = pk;
        it.hdl   = h;
        return it;
    endfunction

    function automatic arp_item_t mk_tick(logic [31:0] el);
        arp_item_t it;
        it    = blank_item();
        it.el = el;
        return it;
    endfunction

    function automatic arp_item_t random_item();
        arp_item_t it;
        int        r;
        logic [47:0] d;
        r = $urandom_range(99);
        d = ($urandom_range(3) == 0) ? MAC_BCAST :
            ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) : m_own_mac;
        if (r < 35)
            it = mk_send(ip_pool[$urandom_range(39)], 16'($urandom));
        else if (r < 58)
            it = mk_frame(d, FT_ARP, ARP_REPLY, ip_pool[$urandom_range(39)],
                          mac_pool[$urandom_range(7)] ^ 48'({$urandom, $urandom}), $urandom,
                          1'($urandom), 16'($urandom));
        else if (r < 68)
            it = mk_frame(d, FT_ARP, ARP_REQ, ip_pool[$urandom_range(39)],
                          48'({$urandom, $urandom}),
                          ($urandom_range(4) == 0) ? $urandom : m_own_ip, 1'($urandom),
                          16'($urandom));
        else if (r < 78)
            it = mk_frame(d, FT_IPV4, 2'($urandom), $urandom, 48'({$urandom, $urandom}),
                          $urandom, ($urandom_range(4) != 0), 16'($urandom));
        else if (r < 91)
            it = mk_tick(($urandom_range(9) == 0) ? $urandom : $urandom_range(3000));
        else
        begin
            it = '{op: 2'($urandom), nh_ip: $urandom, hdl: 16'($urandom),
                   fdst: 48'({$urandom, $urandom}), ftype: 2'($urandom), opc: 2'($urandom),
                   sip: $urandom, smac: 48'({$urandom, $urandom}), tip: $urandom,
                   pok: 1'($urandom), el: $urandom};
        end
        return it;
    endfunction

    // called at a falling edge; returns at a falling edge once the transaction is taken
    task automatic drive_item(arp_item_t it, int idle_pct, chk_mode_t mode, arp_result_t res);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        operation       <= it.op;
        next_hop_ip     <= it.nh_ip;
        datagram_handle <= it.hdl;
        frame_dst_mac   <= it.fdst;
        frame_type      <= it.ftype;
        arp_opcode      <= it.opc;
        sender_ip       <= it.sip;
        sender_mac      <= it.smac;
        target_ip       <= it.tip;
        payload_ok      <= it.pok;
        elapsed_ms      <= it.el;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict(it);
        if (mode == CHK_TYPED)
            expected_results.insert(expected_results.size(), res);
        else if (mode == CHK_MODEL)
            foreach (step_out[i])
                expected_results.insert(expected_results.size(), step_out[i]);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // one write per call; the enable drops between writes
    task automatic write_reg(logic [1:0] idx, logic [47:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_OWN_MAC:  m_own_mac  = data;
            REG_OWN_IP:   m_own_ip   = data[31:0];
            REG_LIFETIME: m_lifetime = data[15:0];
            REG_RETRY:    m_retry    = data[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic random_phase(int n, int in_pct);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain();
            drive_item(random_item(), in_pct, CHK_MODEL, '{default: '0});
        end
        drain();
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            arp_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind %0d handle %h", kind, handle_out);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind: expected %0d actual %0d", e.kind, kind);
                    errors++;
                end
                if (dst_mac !== e.dmac)
                begin
                    $error("dst_mac: expected %h actual %h", e.dmac, dst_mac);
                    errors++;
                end
                if (arp_target_ip !== e.tip)
                begin
                    $error("arp_target_ip: expected %h actual %h", e.tip, arp_target_ip);
                    errors++;
                end
                if (arp_target_mac !== e.tmac)
                begin
                    $error("arp_target_mac: expected %h actual %h", e.tmac, arp_target_mac);
                    errors++;
                end
                if (handle_out !== e.hdl)
                begin
                    $error("handle_out: expected %h actual %h", e.hdl, handle_out);
                    errors++;
                end
                if (last !== e.lst)
                begin
                    $error("last: expected %b actual %b", e.lst, last);
                    errors++;
                end
            end
        end

    initial
    begin
        dir_row_t    rows[$];
        arp_result_t none;
        logic [47:0] me;
        logic [31:0] ip_a;
        logic [31:0] ip_b;

        none = '{default: '0};
        m_own_mac  = '0;
        m_own_ip   = '0;
        m_lifetime = LIFETIME_RESET;
        m_retry    = RETRY_RESET;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            c_valid[i] = 1'b0;
        for (int i = 0; i < PENDING_ENTRIES; i++)
            p_valid[i] = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_valid[i] = 1'b0;
        foreach (ip_pool[i])
            ip_pool[i] = $urandom;
        foreach (mac_pool[i])
            mac_pool[i] = 48'({$urandom, $urandom});

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        me   = 48'h0200_0000_0001;
        ip_a = 32'hFFFF_FFFF;
        ip_b = 32'h0000_0000;
        write_reg(REG_OWN_MAC, me);
        write_reg(REG_OWN_IP, 48'h0A00_0001);

        rows.insert(rows.size(), '{mk_send(ip_a, 16'h0001), CHK_TYPED,
                    '{KIND_REQUEST, MAC_BCAST, ip_a, 48'd0, 16'd0, 1'b1}});
        rows.insert(rows.size(), '{mk_send(ip_a, 16'hFFFF), CHK_MODEL, none});
        rows.insert(rows.size(), '{mk_send(ip_b, 16'h0000), CHK_MODEL, none});
        rows.insert(rows.size(), '{mk_frame(me, FT_ARP, ARP_REPLY, ip_a, MAC_BCAST, 32'd0,
                                            1'b0, 16'd0), CHK_MODEL, none});
        rows.insert(rows.size(), '{mk_send(ip_a, 16'h1234), CHK_MODEL, none});
        rows.insert(rows.size(), '{mk_frame(MAC_BCAST, FT_ARP, ARP_REQ, ip_b, 48'd0,
                                            32'h0A00_0001, 1'b0, 16'd0), CHK_MODEL, none});
        rows.insert(rows.size(), '{mk_send(ip_b, 16'h0002), CHK_MODEL, none});
        // request aimed at another host
        rows.insert(rows.size(), '{mk_frame(MAC_BCAST, FT_ARP, ARP_REQ, 32'h1, 48'h5,
                                            32'h0A00_0002, 1'b0, 16'd0), CHK_NONE, none});
        // frame for someone else
        rows.insert(rows.size(), '{mk_frame(48'h0200_0000_0002, FT_IPV4, ARP_REQ, 32'd0, 48'd0,
                                            32'd0, 1'b1, 16'h7), CHK_NONE, none});
        rows.insert(rows.size(), '{mk_frame(me, FT_IPV4, ARP_REQ, 32'd0, 48'd0, 32'd0, 1'b0,
                                            16'h8), CHK_NONE, none});
        rows.insert(rows.size(), '{mk_frame(MAC_BCAST, FT_IPV4, ARP_REQ, 32'd0, 48'd0, 32'd0,
                                            1'b1, 16'hFFFF), CHK_TYPED,
                    '{KIND_DELIVER, 48'd0, 32'd0, 48'd0, 16'hFFFF, 1'b1}});
        rows.insert(rows.size(), '{mk_frame(me, 2'd2, ARP_REQ, 32'd0, 48'd0, 32'h0A00_0001,
                                            1'b1, 16'd1), CHK_NONE, none});
        rows.insert(rows.size(), '{mk_frame(me, 2'd3, ARP_REQ, 32'd0, 48'd0, 32'h0A00_0001,
                                            1'b1, 16'd1), CHK_NONE, none});
        rows.insert(rows.size(), '{mk_frame(me, FT_ARP, 2'd2, 32'd1, 48'd1, 32'h0A00_0001,
                                            1'b1, 16'd1), CHK_NONE, none});
        rows.insert(rows.size(), '{mk_frame(me, FT_ARP, 2'd3, 32'd1, 48'd1, 32'h0A00_0001,
                                            1'b1, 16'd1), CHK_NONE, none});
        begin
            arp_item_t bad;
            bad    = mk_send(32'h3, 16'h3);
            bad.op = 2'd3;
            rows.insert(rows.size(), '{bad, CHK_NONE, none});
        end
        rows.insert(rows.size(), '{mk_tick(32'd0), CHK_NONE, none});
        rows.insert(rows.size(), '{mk_tick(32'hFFFF_FFFF), CHK_NONE, none});
        rows.insert(rows.size(), '{mk_send(ip_a, 16'h0003), CHK_MODEL, none});
        // fill the queue past its depth, then resolve the filling address
        for (int i = 0; i < QUEUE_DEPTH; i++)
            rows.insert(rows.size(), '{mk_send(32'h0A00_0063, 16'(16'h100 + i)), CHK_MODEL,
                                       none});
        rows.insert(rows.size(), '{mk_frame(me, FT_ARP, ARP_REPLY, 32'h0A00_0063, 48'hABCD,
                                            32'd0, 1'b0, 16'd0), CHK_MODEL, none});

        out_pct = 58;
        foreach (rows[i])
            drive_item(rows[i].it, 9, rows[i].mode, rows[i].res);
        drain();

        write_reg(REG_LIFETIME, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_RETRY, 48'd65535);
        random_phase(135, 9);

        out_pct = 9;
        write_reg(REG_OWN_MAC, 48'({$urandom, $urandom}));
        write_reg(REG_OWN_IP, 48'hFFFF_FFFF);
        write_reg(REG_LIFETIME, 48'd1);
        write_reg(REG_RETRY, 48'd1);
        random_phase(135, 58);

        out_pct = 0;
        write_reg(REG_OWN_MAC, 48'd0);
        write_reg(REG_OWN_IP, 48'd0);
        write_reg(REG_LIFETIME, 48'd30000);
        write_reg(REG_RETRY, 48'd5000);
        random_phase(135, 0);

        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
        begin
            if (expected_results.size() != 0)
                $error("%0d expected results never arrived", expected_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
